FILE: sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and codes for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam logic [1:0] FUNC_PRINT = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_RETURN  = 8'd13;

	localparam logic [2:0] OP_PRINT   = 3'd0;
	localparam logic [2:0] OP_NEWLINE = 3'd1;
	localparam logic [2:0] OP_RETURN  = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;
	localparam logic [2:0] OP_NOP     = 3'd5;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  ch;
		logic [7:0]  attr;
		logic [10:0] idx;
		logic        idx_ok;
	} cmd_t;

endpackage

FILE: sv/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front
// Accepts command words and classifies them into operations for the queue.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; #(
	parameter int CELLS = 2000
) (
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr,
	input  logic [10:0] cell_index,
	input  logic        q_full,
	input  logic        back_busy,
	output logic        push,
	output cmd_t        push_cmd
);

	assign cmd_stall = q_full | back_busy;
	assign push      = cmd_valid & ~cmd_stall;

	always_comb begin
		push_cmd.ch     = char_code;
		push_cmd.attr   = attr;
		push_cmd.idx    = cell_index;
		push_cmd.idx_ok = 32'(cell_index) < 32'(CELLS);
		unique case (func)
			FUNC_PRINT: begin
				priority if (char_code == CHAR_NEWLINE) push_cmd.op = OP_NEWLINE;
				else if (char_code == CHAR_RETURN)      push_cmd.op = OP_RETURN;
				else                                    push_cmd.op = OP_PRINT;
			end
			FUNC_CLEAR: push_cmd.op = OP_CLEAR;
			FUNC_READ:  push_cmd.op = OP_READ;
			default:    push_cmd.op = OP_NOP;
		endcase
	end

endmodule

FILE: sv/tccw_queue.sv
// ----------------------------------------------------------------------------
// tccw_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module tccw_queue import tccw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back
// Executes operations on the cell store and cursor; walks the store for
// scroll, clear and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       busy,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_col,
	output logic       scrolled,
	output logic [7:0] read_char,
	output logic [7:0] read_attr
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLS + 1);

	localparam logic [AW:0]   CELLS_N    = (AW + 1)'(CELLS);
	localparam logic [AW:0]   CELLS_LAST = (AW + 1)'(CELLS - 1);
	localparam logic [AW:0]   COLS_N     = (AW + 1)'(COLS);
	localparam logic [AW:0]   LAST_ROW_N = (AW + 1)'(CELLS - COLS);
	localparam logic [RW-1:0] ROWS_R     = RW'(ROWS);
	localparam logic [CW-1:0] COLS_C     = CW'(COLS);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_APPLY  = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_BLANK  = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	logic [2:0]    state_q;
	logic [AW:0]   addr_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	cmd_t          cmd_q;
	logic          scrolled_q;
	logic          pend_s1;
	logic [AW-1:0] waddr_s1;
	logic          out_valid_q;
	logic [4:0]    out_row_q;
	logic [6:0]    out_col_q;
	logic          out_scr_q;
	logic [7:0]    out_ch_q;
	logic [7:0]    out_at_q;

	cmd_t          cur;
	logic          act;
	logic [AW:0]   cur_lin;
	logic [AW:0]   src_back;
	logic          out_free;
	logic          fin_fire;
	logic          rd_ok;

	assign cur      = (state_q == ST_IDLE) ? q_cmd : cmd_q;
	assign act      = (state_q == ST_APPLY) || (state_q == ST_IDLE && q_valid);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign busy     = state_q == ST_INIT;
	assign cur_lin  = (AW + 1)'(row_q) * COLS_N + (AW + 1)'(col_q);
	assign src_back = addr_q - COLS_N;
	assign out_free = ~out_valid_q | ~res_stall;
	assign fin_fire = (state_q == ST_FIN) && out_free;
	assign rd_ok    = (cmd_q.op == OP_READ) && cmd_q.idx_ok;

	assign res_valid  = out_valid_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;
	assign scrolled   = out_scr_q;
	assign read_char  = out_ch_q;
	assign read_attr  = out_at_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q[AW-1:0];
			end
			ST_IDLE, ST_APPLY: begin
				if (act && cur.op == OP_PRINT && row_q != ROWS_R && col_q != COLS_C) begin
					mem_we    = 1'b1;
					mem_waddr = cur_lin[AW-1:0];
					mem_wdata = {cur.attr, cur.ch};
				end
				if (q_pop && cur.op == OP_READ && cur.idx_ok) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(cur.idx);
				end
			end
			ST_SCROLL: begin
				mem_we    = pend_s1;
				mem_waddr = waddr_s1;
				mem_wdata = rdata_q;
				mem_re    = addr_q < CELLS_N;
				mem_raddr = addr_q[AW-1:0];
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q[AW-1:0];
				mem_wdata = {cmd_q.attr, 8'h00};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			addr_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fin_fire | (out_valid_q & res_stall);
			unique case (state_q)
				ST_INIT: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == CELLS_LAST) state_q <= ST_IDLE;
				end
				ST_IDLE, ST_APPLY: begin
					if (act) begin
						if (state_q == ST_IDLE) begin
							cmd_q      <= q_cmd;
							scrolled_q <= 1'b0;
						end
						unique case (cur.op)
							OP_CLEAR: begin
								addr_q  <= '0;
								row_q   <= '0;
								col_q   <= '0;
								state_q <= ST_BLANK;
							end
							OP_PRINT, OP_NEWLINE, OP_RETURN: begin
								if (row_q == ROWS_R) begin
									scrolled_q <= 1'b1;
									row_q      <= row_q - 1'b1;
									col_q      <= '0;
									addr_q     <= COLS_N;
									pend_s1    <= 1'b0;
									state_q    <= ST_SCROLL;
								end else if (cur.op == OP_NEWLINE) begin
									row_q   <= row_q + 1'b1;
									col_q   <= '0;
									state_q <= ST_FIN;
								end else if (cur.op == OP_RETURN) begin
									col_q   <= '0;
									state_q <= ST_FIN;
								end else if (col_q == COLS_C) begin
									row_q   <= row_q + 1'b1;
									col_q   <= '0;
									state_q <= ST_APPLY;
								end else begin
									col_q   <= col_q + 1'b1;
									state_q <= ST_FIN;
								end
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_SCROLL: begin
					if (addr_q < CELLS_N) begin
						addr_q   <= addr_q + 1'b1;
						pend_s1  <= 1'b1;
						waddr_s1 <= src_back[AW-1:0];
					end else begin
						pend_s1 <= 1'b0;
						addr_q  <= LAST_ROW_N;
						state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == CELLS_LAST)
						state_q <= (cmd_q.op == OP_CLEAR) ? ST_FIN : ST_APPLY;
				end
				ST_FIN: begin
					if (out_free) begin
						out_row_q   <= 5'(row_q);
						out_col_q   <= 7'(col_q);
						out_scr_q   <= scrolled_q;
						out_ch_q    <= rd_ok ? rdata_q[7:0] : 8'h00;
						out_at_q    <= rd_ok ? rdata_q[15:8] : 8'h00;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text-mode screen writer with a ROWS x COLS store of character and attribute.
// ----------------------------------------------------------------------------
// After reset the block clears the cell store one cell a cycle and holds
// cmd_stall high meanwhile. A scroll walks the store, one cell copied a
// cycle, and then blanks the last row; a clear blanks the whole store and
// homes the cursor. A two-word queue sits between the command side and the
// store sequencer, and a result register holds the finished word while the
// next command is taken.
module text_console_char_writer_top import tccw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr,
	input  logic [10:0] cell_index,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic        scrolled,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;
	logic back_busy;

	tccw_front #(
		.CELLS(ROWS * COLS)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.func      (func),
		.char_code (char_code),
		.attr      (attr),
		.cell_index(cell_index),
		.q_full    (q_full),
		.back_busy (back_busy),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	tccw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head      (q_cmd)
	);

	tccw_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.busy      (back_busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.scrolled  (scrolled),
		.read_char (read_char),
		.read_attr (read_attr)
	);

endmodule
